// File: rtl/bcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_pkg
// Types, constants and helpers shared by the byte to coefficient packer.
// ----------------------------------------------------------------------------
package bcp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int WORD_BITS = 64;
    localparam int CNT_W     = 7;
    localparam int REST_W    = 4;

    localparam logic [CNT_W-1:0] WIDTH_MIN   = 7'd1;
    localparam logic [CNT_W-1:0] WIDTH_MAX   = 7'd64;
    localparam logic [CNT_W-1:0] WIDTH_RESET = 7'd16;
    localparam logic [REST_W-1:0] REST_FULL  = 4'd8;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 element_end;
    } bcp_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] coeff_word;
        logic                 last_coeff;
    } bcp_out_t;

    typedef struct packed {
        logic emit;
        logic done;
    } bcp_step_ctl_t;

    function automatic logic [CNT_W-1:0] eff_width(input logic [CNT_W-1:0] bits);
        logic [CNT_W-1:0] w;
        w = bits;
        if (bits == '0) begin
            w = WIDTH_MIN;
        end else if (bits > WIDTH_MAX) begin
            w = WIDTH_MAX;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/byte_to_coefficient_packer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_to_coefficient_packer_unit
// Packs element bytes, most significant bit first, into coefficients.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_data carries one byte and an element end
// flag per transfer. Result channel m_valid/m_ready/m_data carries one
// coefficient, right aligned, with last_coeff set on the element's final one.
// The cfg channel writes the coefficient width (0 acts as 1, above 64 as 64)
// and drops any partial coefficient; cfg_ready is always high.
// Each accepted byte is held in the byte register, and the packing step loads
// each coefficient that it yields into the result register, which drives m_valid.
// Throughput: one byte per cycle as long as a byte yields at most one
// coefficient and the receiver does not stall; the byte register holds a byte
// for one packing step per coefficient it yields, the flush included, and for
// at least one step (up to eight for a width of one).
// Reset clears all pending transfers and sets the width to 16 with an empty
// coefficient. A stalled receiver holds the result register, which in turn
// holds the byte register and, while that holds a byte, deasserts s_ready.
// ----------------------------------------------------------------------------
module byte_to_coefficient_packer_unit
    import bcp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  bcp_in_t               s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bcp_out_t              m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0]     coeff_bits_reg;
    logic [WORD_BITS-1:0] partial_reg;
    logic [CNT_W-1:0]     free_reg;
    logic                 busy_reg;
    logic [BYTE_BITS-1:0] src_reg;
    logic [REST_W-1:0]    rest_reg;
    logic                 last_reg;

    logic [CNT_W-1:0]     width;
    bcp_step_ctl_t        step_ctl;
    bcp_out_t             step_item;
    logic [WORD_BITS-1:0] partial_next;
    logic [CNT_W-1:0]     free_next;
    logic [BYTE_BITS-1:0] src_next;
    logic [REST_W-1:0]    rest_next;
    logic                 slot_free;
    logic                 advance;
    logic                 s_xfer;
    logic                 cfg_xfer;

    assign width     = eff_width(coeff_bits_reg);
    assign advance   = busy_reg && slot_free;
    assign s_ready   = !busy_reg || (slot_free && step_ctl.done);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid;

    bcp_pack_step u_step (
        .partial      (partial_reg),
        .free         (free_reg),
        .width        (width),
        .src          (src_reg),
        .rest         (rest_reg),
        .last         (last_reg),
        .ctl          (step_ctl),
        .item         (step_item),
        .partial_next (partial_next),
        .free_next    (free_next),
        .src_next     (src_next),
        .rest_next    (rest_next)
    );

    bcp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && step_ctl.emit),
        .load_item (step_item),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_bits_reg <= WIDTH_RESET;
            partial_reg    <= '0;
            free_reg       <= WIDTH_RESET;
        end else if (cfg_xfer) begin
            coeff_bits_reg <= cfg_data;
            partial_reg    <= '0;
            free_reg       <= eff_width(cfg_data);
        end else if (advance) begin
            partial_reg <= partial_next;
            free_reg    <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_xfer) begin
            busy_reg <= 1'b1;
        end else if (advance && step_ctl.done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            src_reg  <= s_data.data_byte;
            rest_reg <= REST_FULL;
            last_reg <= s_data.element_end;
        end else if (advance && !step_ctl.done) begin
            src_reg  <= src_next;
            rest_reg <= rest_next;
        end
    end

    a_free_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg != '0) && (free_reg <= width))
        else $error("free bit count out of range");

    a_accept_loads_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> busy_reg && (rest_reg == REST_FULL))
        else $error("accepted byte not held");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_ctl.emit && step_item.last_coeff
        |=> (free_reg == width) && (partial_reg == '0))
        else $error("packing not restarted after last coefficient");

endmodule
`default_nettype wire

// File: rtl/bcp_pack_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_pack_step
// One packing step: moves bits of the held byte into the partial coefficient
// and yields at most one coefficient.
// ----------------------------------------------------------------------------
module bcp_pack_step
    import bcp_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] partial,
    input  wire logic [CNT_W-1:0]     free,
    input  wire logic [CNT_W-1:0]     width,
    input  wire logic [BYTE_BITS-1:0] src,
    input  wire logic [REST_W-1:0]    rest,
    input  wire logic                 last,
    output bcp_step_ctl_t             ctl,
    output bcp_out_t                  item,
    output logic [WORD_BITS-1:0]      partial_next,
    output logic [CNT_W-1:0]          free_next,
    output logic [BYTE_BITS-1:0]      src_next,
    output logic [REST_W-1:0]         rest_next
);

    logic [REST_W-1:0]    take;
    logic [WORD_BITS-1:0] pw1;
    logic [CNT_W-1:0]     free1;
    logic [REST_W-1:0]    rest1;
    logic [BYTE_BITS-1:0] src1;
    logic                 full;

    always_comb begin
        take  = (free < {3'b000, rest}) ? free[REST_W-1:0] : rest;
        pw1   = (partial << take) | {{(WORD_BITS-BYTE_BITS){1'b0}}, src >> (REST_FULL - take)};
        free1 = free - {3'b000, take};
        rest1 = rest - take;
        src1  = src << take;
        full  = (free1 == '0);

        ctl          = '{emit: 1'b0, done: 1'b1};
        item         = '{coeff_word: pw1, last_coeff: 1'b0};
        partial_next = '0;
        free_next    = width;
        src_next     = src1;
        rest_next    = rest1;

        if (full) begin
            ctl.emit        = 1'b1;
            item.last_coeff = last && (rest1 == '0);
            if (rest1 != '0) begin
                if (({3'b000, rest1} < width) && !last) begin
                    // remaining bits fit a fresh coefficient
                    partial_next = {{(WORD_BITS-BYTE_BITS){1'b0}}, src1 >> (REST_FULL - rest1)};
                    free_next    = width - {3'b000, rest1};
                end else begin
                    ctl.done = 1'b0;
                end
            end
        end else if (last) begin
            // flush partial coefficient, zeros in the low bits
            ctl.emit        = 1'b1;
            item.coeff_word = pw1 << free1[5:0];
            item.last_coeff = 1'b1;
        end else begin
            partial_next = pw1;
            free_next    = free1;
        end
    end

endmodule
`default_nettype wire

// File: rtl/bcp_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_out_reg
// Result register between the packing step and the result channel.
// ----------------------------------------------------------------------------
module bcp_out_reg
    import bcp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load,
    input  bcp_out_t      load_item,
    output logic          slot_free,
    output logic          m_valid,
    input  wire logic     m_ready,
    output bcp_out_t      m_data
);

    logic     valid_reg;
    bcp_out_t data_reg;

    assign slot_free = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_data    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_item;
        end
    end

endmodule
`default_nettype wire

// File: tb/byte_to_coefficient_packer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_coefficient_packer_unit_test
// Self-checking bench for the byte to coefficient packer.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, out of range widths, a final
// byte that exactly fills a coefficient, a flush after a full coefficient and
// a width write that drops a partial coefficient. Random phases then run
// elements of random length under random widths. A behavioral packing model
// predicts every coefficient not typed into the table, and the results are
// compared in order; in most phases both sides insert random idle bursts.
// ----------------------------------------------------------------------------
module byte_to_coefficient_packer_unit_test
    import bcp_pkg::*;
();

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_BYTES   = 38;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 31;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [7:0]           value;
        logic                 fin;
        logic                 typed;
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 64'hFF00, 1'b1},
        '{ROW_BYTE, 8'hA5, 1'b1, 1'b1, 64'hA500, 1'b1},
        '{ROW_CFG,  8'd8,  1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b1, 64'h80, 1'b0},
        '{ROW_BYTE, 8'h01, 1'b1, 1'b1, 64'h01, 1'b1},
        '{ROW_CFG,  8'd0,  1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_CFG,  8'd64, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        '{ROW_BYTE, 8'h12, 1'b1, 1'b1, 64'h1200_0000_0000_0000, 1'b1},
        '{ROW_CFG,  8'd127, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h01, 1'b1, 1'b1, 64'h0100_0000_0000_0000, 1'b1},
        '{ROW_CFG,  8'd3,  1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hB7, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 64'h0, 1'b0},
        '{ROW_CFG,  8'd12, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hC3, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h3C, 1'b1, 1'b0, 64'h0, 1'b0},
        '{ROW_CFG,  8'd16, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'hAB, 1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_CFG,  8'd8,  1'b0, 1'b0, 64'h0, 1'b0},
        '{ROW_BYTE, 8'h5A, 1'b1, 1'b1, 64'h5A, 1'b1}
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    bcp_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    bcp_out_t         m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // packing model state
    int                   width_eff;
    int                   free_cnt;
    logic [WORD_BITS-1:0] part_word;
    bcp_out_t             packed_now[$];
    bcp_out_t             pending_coeffs[$];

    int idle_pct = 25;
    int stall_left = 0;
    int cycle_cnt = 0;
    int fail_cnt = 0;
    int bytes_sent = 0;
    int elements_sent = 0;
    int coeffs_seen = 0;
    int widths_written = 0;

    byte_to_coefficient_packer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d coefficients outstanding",
                     cycle_cnt, pending_coeffs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void set_width(input logic [CNT_W-1:0] bits);
        if (bits < WIDTH_MIN) begin
            width_eff = int'(WIDTH_MIN);
        end else if (bits > WIDTH_MAX) begin
            width_eff = int'(WIDTH_MAX);
        end else begin
            width_eff = int'(bits);
        end
        free_cnt  = width_eff;
        part_word = '0;
    endfunction

    function automatic void pack_byte(input bcp_in_t item);
        logic [BYTE_BITS-1:0] src;
        logic [WORD_BITS-1:0] chunk;
        int                   rest;
        int                   take;
        bcp_out_t             res;
        packed_now.delete();
        src  = item.data_byte;
        rest = BYTE_BITS;
        if (free_cnt == 0 || free_cnt > width_eff) begin
            free_cnt  = width_eff;
            part_word = '0;
        end
        while (rest != 0) begin
            take      = (free_cnt < rest) ? free_cnt : rest;
            chunk     = {{(WORD_BITS-BYTE_BITS){1'b0}}, src} >> (BYTE_BITS - take);
            part_word = (part_word << take) | chunk;
            src       = src << take;
            free_cnt  -= take;
            rest      -= take;
            if (free_cnt == 0) begin
                res.coeff_word = part_word;
                res.last_coeff = item.element_end && (rest == 0);
                packed_now.insert(packed_now.size(), res);
                part_word = '0;
                free_cnt  = width_eff;
            end
        end
        // flush of a partial coefficient, zeros in the low bits
        if (item.element_end && free_cnt < width_eff) begin
            res.coeff_word = part_word << free_cnt;
            res.last_coeff = 1'b1;
            packed_now.insert(packed_now.size(), res);
            part_word = '0;
            free_cnt  = width_eff;
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return CNT_W'($urandom_range(65, 127));
        end else if (r < 5) begin
            return CNT_W'($urandom_range(1, 7));
        end else if (r < 8) begin
            return CNT_W'($urandom_range(33, 64));
        end
        return CNT_W'($urandom_range(8, 32));
    endfunction

    task automatic send_byte(input bcp_in_t item, input logic typed, input bcp_out_t typed_coeff);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pack_byte(item);
        if (typed) begin
            pending_coeffs.insert(pending_coeffs.size(), typed_coeff);
        end else begin
            foreach (packed_now[i]) pending_coeffs.insert(pending_coeffs.size(), packed_now[i]);
        end
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_coeffs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CNT_W-1:0] bits);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_width(bits);
        widths_written++;
    endtask

    task automatic check_coeff(input bcp_out_t got);
        bcp_out_t want;
        coeffs_seen++;
        if (pending_coeffs.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
                $display("unexpected coefficient: word %h last %0b",
                         got.coeff_word, got.last_coeff);
            end
        end else begin
            want = pending_coeffs.pop_front();
            if (got.coeff_word !== want.coeff_word || got.last_coeff !== want.last_coeff) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS) begin
                    $display("coefficient %0d: expected word %h last %0b, got word %h last %0b",
                             coeffs_seen, want.coeff_word, want.last_coeff,
                             got.coeff_word, got.last_coeff);
                end
            end
        end
    endtask

    // result side: check each transfer, then pick the next ready level
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_coeff(m_data);
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
                stall_left = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        dir_row_t row;
        int       phase_bytes;
        int       burst_len;
        logic     held;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        held      = 1'b0;
        set_width(WIDTH_RESET);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                write_width(row.value[CNT_W-1:0]);
            end else begin
                send_byte('{data_byte: row.value, element_end: row.fin}, row.typed,
                          '{coeff_word: row.word, last_coeff: row.last});
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1 || $urandom_range(0, 3) == 0) begin
                idle_pct = 0;
            end else begin
                idle_pct = $urandom_range(10, 40);
            end
            write_width(pick_width());
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                // hold the input once until every coefficient is out
                if (phase == RANDOM_PHASES / 2 && !held && phase_bytes >= PHASE_BYTES / 2) begin
                    wait_drained();
                    held = 1'b1;
                end
                if ($urandom_range(0, 9) < 8) begin
                    burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                            : $urandom_range(1, 8);
                    for (int k = 0; k < burst_len; k++) begin
                        send_byte('{data_byte: rand_byte(), element_end: (k == burst_len - 1)},
                                  1'b0, '0);
                    end
                    phase_bytes += burst_len;
                    elements_sent++;
                end else begin
                    send_byte('{data_byte: rand_byte(), element_end: ($urandom_range(0, 1) == 1)},
                              1'b0, '0);
                    phase_bytes++;
                end
            end
        end

        wait_drained();
        $display("packed %0d bytes, %0d random elements, over %0d width writes",
                 bytes_sent, elements_sent, widths_written);
        $display("checked %0d coefficients, %0d failures", coeffs_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/bcp_pkg.sv
rtl/bcp_pack_step.sv
rtl/bcp_out_reg.sv
rtl/byte_to_coefficient_packer_unit.sv
tb/byte_to_coefficient_packer_unit_test.sv
